// ===== sv/pel_pkg.sv =====
// Shared types, codes and constants of the PIN entry lock controller.
// Used by pel_cfg, pel_core, pin_entry_lock_controller and the testbench; depends on nothing.
package pel_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_PIN_CODE     = 3'd0;
	localparam logic [2:0] REG_MAX_ATTEMPTS = 3'd1;
	localparam logic [2:0] REG_KEY_GAP      = 3'd2;
	localparam logic [2:0] REG_OPEN         = 3'd3;
	localparam logic [2:0] REG_ERROR        = 3'd4;
	localparam logic [2:0] REG_LOCKOUT      = 3'd5;

	localparam logic [15:0] PIN_CODE_RST     = 16'h1234;
	localparam logic [1:0]  MAX_ATTEMPTS_RST = 2'd3;
	localparam logic [15:0] KEY_GAP_RST      = 16'd200;
	localparam logic [15:0] OPEN_RST         = 16'd2000;
	localparam logic [15:0] ERROR_RST        = 16'd2000;
	localparam logic [15:0] LOCKOUT_RST      = 16'd62000;

	localparam logic [1:0] MODE_ENTRY  = 2'd0;
	localparam logic [1:0] MODE_OPEN   = 2'd1;
	localparam logic [1:0] MODE_WRONG  = 2'd2;
	localparam logic [1:0] MODE_LOCKED = 2'd3;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_KEY     = 3'd1;
	localparam logic [2:0] EV_MATCH   = 3'd2;
	localparam logic [2:0] EV_MISS    = 3'd3;
	localparam logic [2:0] EV_LOCKOUT = 3'd4;
	localparam logic [2:0] EV_READY   = 3'd5;

	localparam logic REQ_KEY  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [6:0] SEG_BLANK = 7'h00;

	typedef struct packed {
		logic [15:0] pin_code;
		logic [1:0]  max_attempts;
		logic [15:0] key_gap_ticks;
		logic [15:0] open_ticks;
		logic [15:0] error_ticks;
		logic [15:0] lockout_ticks;
	} cfg_t;

	typedef struct packed {
		logic       req_type;
		logic [1:0] key_row;
		logic [1:0] key_col;
	} item_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] digits_entered;
		logic [1:0] tries_left;
		logic [6:0] segment_pattern;
		logic       door_buzzer;
		logic [2:0] event_code;
	} result_t;

	// seven-segment pattern for the digits 0 to 3
	function automatic logic [6:0] seg_digit(input logic [1:0] d);
		logic [6:0] s;
		case (d)
			2'd0:    s = 7'h3F;
			2'd1:    s = 7'h06;
			2'd2:    s = 7'h5B;
			default: s = 7'h4F;
		endcase
		return s;
	endfunction

endpackage

// ===== sv/pel_cfg.sv =====
// APB-style register file of the PIN entry lock controller.
// Depends on pel_pkg for the register indexes, reset values and cfg_t.
module pel_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pel_pkg::ADDR_W-1:0] paddr,
	input  logic [pel_pkg::DATA_W-1:0] pwdata,
	output logic [pel_pkg::DATA_W-1:0] prdata,
	output pel_pkg::cfg_t              cfg
);
	import pel_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign wr_en = psel & penable & pwrite;
	assign idx   = paddr[4:2];
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pin_code      <= PIN_CODE_RST;
			cfg_q.max_attempts  <= MAX_ATTEMPTS_RST;
			cfg_q.key_gap_ticks <= KEY_GAP_RST;
			cfg_q.open_ticks    <= OPEN_RST;
			cfg_q.error_ticks   <= ERROR_RST;
			cfg_q.lockout_ticks <= LOCKOUT_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_PIN_CODE:     cfg_q.pin_code      <= pwdata[15:0];
				REG_MAX_ATTEMPTS: cfg_q.max_attempts  <= pwdata[1:0];
				REG_KEY_GAP:      cfg_q.key_gap_ticks <= pwdata[15:0];
				REG_OPEN:         cfg_q.open_ticks    <= pwdata[15:0];
				REG_ERROR:        cfg_q.error_ticks   <= pwdata[15:0];
				REG_LOCKOUT:      cfg_q.lockout_ticks <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PIN_CODE:     prdata = {16'd0, cfg_q.pin_code};
			REG_MAX_ATTEMPTS: prdata = {30'd0, cfg_q.max_attempts};
			REG_KEY_GAP:      prdata = {16'd0, cfg_q.key_gap_ticks};
			REG_OPEN:         prdata = {16'd0, cfg_q.open_ticks};
			REG_ERROR:        prdata = {16'd0, cfg_q.error_ticks};
			REG_LOCKOUT:      prdata = {16'd0, cfg_q.lockout_ticks};
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== sv/pel_core.sv =====
// Lock state and next-state logic: mode, collected digits, attempts, hold timer
// and display. Depends on pel_pkg; the state advances once per step.
module pel_core #(
	parameter int CODE_DIGITS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  pel_pkg::item_t   item,
	input  pel_pkg::cfg_t    cfg,
	output pel_pkg::result_t res
);
	import pel_pkg::*;

	localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

	logic [1:0]  mode_q, mode_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [1:0]  tries_q, tries_d;
	logic [15:0] timer_q, timer_d;
	logic [6:0]  seg_q, seg_d;
	logic [2:0]  ev;
	logic [3:0]  digits_q [CODE_DIGITS];
	logic [3:0]  key;
	logic        take_key;
	logic        last_key;
	logic        match;
	logic [3:0]  dig;
	logic [1:0]  tries_dec;

	assign key       = {item.key_row, item.key_col};
	assign take_key  = (item.req_type == REQ_KEY) && (mode_q == MODE_ENTRY) &&
	                   (timer_q == 16'd0) && (cnt_q < 3'(CODE_DIGITS));
	assign last_key  = (cnt_q == 3'(CODE_DIGITS - 1));
	assign tries_dec = tries_q - 2'd1;

	// the digit being keyed now stands in for its not yet written entry
	always_comb begin
		match = 1'b1;
		for (int i = 0; i < CODE_DIGITS; i++) begin
			dig = (cnt_q == 3'(i)) ? key : digits_q[i];
			if (dig != cfg.pin_code[15-4*i -: 4])
				match = 1'b0;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		cnt_d   = cnt_q;
		tries_d = tries_q;
		timer_d = timer_q;
		seg_d   = seg_q;
		ev      = EV_NONE;
		if (item.req_type == REQ_TICK) begin
			if (mode_q == MODE_ENTRY) begin
				if (timer_q != 16'd0)
					timer_d = timer_q - 16'd1;
			end else if (timer_q <= 16'd1) begin
				timer_d = 16'd0;
				if (mode_q == MODE_LOCKED)
					tries_d = cfg.max_attempts;
				mode_d = MODE_ENTRY;
				ev     = EV_READY;
			end else begin
				timer_d = timer_q - 16'd1;
			end
		end else if (take_key) begin
			if (!last_key) begin
				cnt_d   = cnt_q + 3'd1;
				timer_d = cfg.key_gap_ticks;
				ev      = EV_KEY;
			end else begin
				cnt_d = 3'd0;
				if (match) begin
					mode_d  = MODE_OPEN;
					timer_d = cfg.open_ticks;
					tries_d = cfg.max_attempts;
					ev      = EV_MATCH;
				end else if (tries_q <= 2'd1) begin
					tries_d = 2'd0;
					seg_d   = seg_digit(2'd0);
					mode_d  = MODE_LOCKED;
					timer_d = cfg.lockout_ticks;
					ev      = EV_LOCKOUT;
				end else begin
					tries_d = tries_dec;
					seg_d   = seg_digit(tries_dec);
					mode_d  = MODE_WRONG;
					timer_d = cfg.error_ticks;
					ev      = EV_MISS;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ENTRY;
			cnt_q   <= 3'd0;
			tries_q <= MAX_ATTEMPTS_RST;
			timer_q <= 16'd0;
			seg_q   <= SEG_BLANK;
		end else if (step) begin
			mode_q  <= mode_d;
			cnt_q   <= cnt_d;
			tries_q <= tries_d;
			timer_q <= timer_d;
			seg_q   <= seg_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && take_key && !last_key)
			digits_q[cnt_q[IDX_W-1:0]] <= key;
	end

	assign res.mode            = mode_d;
	assign res.digits_entered  = cnt_d;
	assign res.tries_left      = tries_d;
	assign res.segment_pattern = seg_d;
	assign res.door_buzzer     = (mode_d == MODE_OPEN);
	assign res.event_code      = ev;

endmodule

// ===== sv/pin_entry_lock_controller.sv =====
// PIN entry lock controller: keypad presses and millisecond ticks in, one status item out.
// Path: input transfer into the input register, then the result register.
// Throughput: one item per cycle unless the output stalls; pel_core's next-state logic is
// combinational. A result waiting on the output side holds the core; one more input
// transfer fits in the input register, then s_tready drops until the result is taken.
// Asynchronous reset clears the handshake, sets entry mode, the reset attempts and
// the reset register values; the collected digits are not reset.
module pin_entry_lock_controller #(
	parameter int CODE_DIGITS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,  // key_row[1:0], key_col[3:2], zero [7:4]
	input  logic                       s_tuser,  // req_type
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// mode[1:0], digits_entered[4:2], tries_left[6:5], segment_pattern[13:7],
	// door_buzzer[14], zero [15]
	output logic [15:0]                m_tdata,
	output logic [2:0]                 m_tuser,  // event_code
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pel_pkg::ADDR_W-1:0] paddr,
	input  logic [pel_pkg::DATA_W-1:0] pwdata,
	output logic [pel_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import pel_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	assign pready   = 1'b1;
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	pel_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	pel_core #(
		.CODE_DIGITS (CODE_DIGITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// payload: load on transfer, hold otherwise
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.req_type <= s_tuser;
			item_s1.key_row  <= s_tdata[1:0];
			item_s1.key_col  <= s_tdata[3:2];
		end
		if (advance)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q.door_buzzer, res_q.segment_pattern, res_q.tries_left,
	                   res_q.digits_entered, res_q.mode};
	assign m_tuser  = res_q.event_code;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for pin_entry_lock_controller: keypad and tick transfers in,
// status transfers out, checked against a cycle-free model of the lock held in a class.
// Depends on pel_pkg and the controller RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pel_pkg::*;

	localparam int DIGITS = 4;
	localparam int LIMIT  = 2000000;
	// seven-segment codes for 0..3, digit 0 in the low bits
	localparam logic [27:0] SEG_CODES = {7'h4F, 7'h5B, 7'h06, 7'h3F};

	class lock_scoreboard;
		cfg_t        cfg;
		logic [1:0]  mode;
		logic [3:0]  digits[4];
		logic [2:0]  count;
		logic [1:0]  tries;
		logic [15:0] hold;
		logic [6:0]  segs;
		result_t     expected_q[$];
		int          failures;
		int          checked;
		int          n_match;
		int          n_miss;
		int          n_lockout;

		function new();
			cfg.pin_code      = PIN_CODE_RST;
			cfg.max_attempts  = MAX_ATTEMPTS_RST;
			cfg.key_gap_ticks = KEY_GAP_RST;
			cfg.open_ticks    = OPEN_RST;
			cfg.error_ticks   = ERROR_RST;
			cfg.lockout_ticks = LOCKOUT_RST;
			mode  = MODE_ENTRY;
			count = 3'd0;
			tries = MAX_ATTEMPTS_RST;
			hold  = 16'd0;
			segs  = SEG_BLANK;
			foreach (digits[i]) digits[i] = 4'd0;
		endfunction

		function logic [31:0] reg_value(logic [2:0] idx);
			case (idx)
				REG_PIN_CODE:     return {16'd0, cfg.pin_code};
				REG_MAX_ATTEMPTS: return {30'd0, cfg.max_attempts};
				REG_KEY_GAP:      return {16'd0, cfg.key_gap_ticks};
				REG_OPEN:         return {16'd0, cfg.open_ticks};
				REG_ERROR:        return {16'd0, cfg.error_ticks};
				default:          return {16'd0, cfg.lockout_ticks};
			endcase
		endfunction

		function bit code_matches();
			for (int i = 0; i < DIGITS; i++)
				if (digits[i] != cfg.pin_code[15-4*i -: 4]) return 1'b0;
			return 1'b1;
		endfunction

		// Advance the lock by one transfer and queue the status it produces.
		// Returns 0 when a key press is dropped.
		function bit take_item(item_t it);
			logic [2:0] ev;
			bit         acted;
			result_t    r;
			ev    = EV_NONE;
			acted = 1'b1;
			if (it.req_type == REQ_TICK) begin
				if (mode == MODE_ENTRY) begin
					if (hold != 16'd0) hold = hold - 16'd1;
				end else if (hold <= 16'd1) begin
					hold = 16'd0;
					if (mode == MODE_LOCKED) tries = cfg.max_attempts;
					mode = MODE_ENTRY;
					ev   = EV_READY;
				end else begin
					hold = hold - 16'd1;
				end
			end else if (mode == MODE_ENTRY && hold == 16'd0 && count < 3'd4) begin
				digits[count[1:0]] = {it.key_row, it.key_col};
				count = count + 3'd1;
				if (count < DIGITS) begin
					hold = cfg.key_gap_ticks;
					ev   = EV_KEY;
				end else begin
					count = 3'd0;
					if (code_matches()) begin
						mode  = MODE_OPEN;
						hold  = cfg.open_ticks;
						tries = cfg.max_attempts;
						ev    = EV_MATCH;
						n_match++;
					end else if (tries <= 2'd1) begin
						tries = 2'd0;
						segs  = SEG_CODES[6:0];
						mode  = MODE_LOCKED;
						hold  = cfg.lockout_ticks;
						ev    = EV_LOCKOUT;
						n_lockout++;
					end else begin
						tries = tries - 2'd1;
						segs  = SEG_CODES[7*tries +: 7];
						mode  = MODE_WRONG;
						hold  = cfg.error_ticks;
						ev    = EV_MISS;
						n_miss++;
					end
				end
			end else begin
				acted = 1'b0;
			end
			r.mode            = mode;
			r.digits_entered  = count;
			r.tries_left      = tries;
			r.segment_pattern = segs;
			r.door_buzzer     = (mode == MODE_OPEN);
			r.event_code      = ev;
			expected_q.push_back(r);
			return acted;
		endfunction

		function void field_check(string field, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				failures++;
			end
		endfunction

		function void check_status(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$error("status transfer with nothing expected: 0x%0h", got);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			field_check("mode", 16'(want.mode), 16'(got.mode));
			field_check("digits_entered", 16'(want.digits_entered), 16'(got.digits_entered));
			field_check("tries_left", 16'(want.tries_left), 16'(got.tries_left));
			field_check("segment_pattern", 16'(want.segment_pattern),
				16'(got.segment_pattern));
			field_check("door_buzzer", 16'(want.door_buzzer), 16'(got.door_buzzer));
			field_check("event_code", 16'(want.event_code), 16'(got.event_code));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;  // key_row[1:0], key_col[3:2], zero [7:4]
	logic                s_tuser;  // req_type
	logic                m_tvalid;
	logic                m_tready;
	// mode[1:0], digits_entered[4:2], tries_left[6:5], segment_pattern[13:7],
	// door_buzzer[14], zero [15]
	logic [15:0]         m_tdata;
	logic [2:0]          m_tuser;  // event_code
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	lock_scoreboard sb;
	result_t        seen_status;
	int             cycle_count;
	int             sent;
	int             effective;
	int             burst_left;
	int             rx_style;
	int             rx_run;
	int             n_settings;
	bit             rush;

	pin_entry_lock_controller #(.CODE_DIGITS(DIGITS)) i_dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: runs of always-ready, random, sparse and fully stalled
	always @(negedge clk) begin
		if (rush) begin
			m_tready <= 1'b1;
		end else begin
			if (rx_run == 0) begin
				rx_style = $urandom_range(0, 3);
				rx_run   = $urandom_range(4, 40);
			end
			rx_run--;
			case (rx_style)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				2:       m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (sb != null && m_tvalid && m_tready) begin
			seen_status.mode            = m_tdata[1:0];
			seen_status.digits_entered  = m_tdata[4:2];
			seen_status.tries_left      = m_tdata[6:5];
			seen_status.segment_pattern = m_tdata[13:7];
			seen_status.door_buzzer     = m_tdata[14];
			seen_status.event_code      = m_tuser;
			sb.check_status(seen_status);
		end
	end

	task automatic send_item(input item_t it);
		int gap;
		gap = 0;
		if (!rush && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
		end
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, it.key_col, it.key_row};
		s_tuser  <= it.req_type;
		do @(posedge clk); while (!s_tready);
		if (sb.take_item(it)) effective++;
		sent++;
		if (burst_left > 0) burst_left--;
	endtask

	task automatic press(input logic [3:0] code);
		item_t it;
		it.req_type = REQ_KEY;
		it.key_row  = code[3:2];
		it.key_col  = code[1:0];
		send_item(it);
	endtask

	task automatic tick();
		item_t it;
		it.req_type = REQ_TICK;
		it.key_row  = 2'($urandom_range(0, 3));
		it.key_col  = 2'($urandom_range(0, 3));
		send_item(it);
	endtask

	// tick through any hold, slipping in presses that must be dropped
	task automatic ride_out();
		while (sb.mode != MODE_ENTRY || sb.hold != 16'd0) begin
			if (!rush && $urandom_range(0, 4) == 0) press(4'($urandom_range(0, 15)));
			else tick();
		end
	endtask

	task automatic enter_code(input logic [15:0] code);
		for (int i = 0; i < DIGITS; i++) begin
			ride_out();
			press(code[15-4*i -: 4]);
		end
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_PIN_CODE:     sb.cfg.pin_code      = val[15:0];
			REG_MAX_ATTEMPTS: sb.cfg.max_attempts  = val[1:0];
			REG_KEY_GAP:      sb.cfg.key_gap_ticks = val[15:0];
			REG_OPEN:         sb.cfg.open_ticks    = val[15:0];
			REG_ERROR:        sb.cfg.error_ticks   = val[15:0];
			REG_LOCKOUT:      sb.cfg.lockout_ticks = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_registers();
		logic [31:0] data;
		for (int i = REG_PIN_CODE; i <= REG_LOCKOUT; i++) begin
			@(negedge clk);
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			paddr   <= {i[2:0], 2'b00};
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			data = prdata;
			if (data !== sb.reg_value(i[2:0])) begin
				$error("prdata reg %0d: expected 0x%0h, got 0x%0h", i, sb.reg_value(i[2:0]), data);
				sb.failures++;
			end
			@(negedge clk);
			psel    <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	initial begin
		logic [15:0] code;
		int          target;
		int          pick;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'd0;
		s_tuser  = REQ_KEY;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		sb       = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_registers();

		// directed: reset PIN, short holds, attempts cap of 2 below the reset count
		cfg_write(REG_KEY_GAP, 32'd0);
		cfg_write(REG_OPEN, 32'd2);
		cfg_write(REG_ERROR, 32'd1);
		cfg_write(REG_LOCKOUT, 32'd0);
		cfg_write(REG_MAX_ATTEMPTS, 32'd2);
		tick();
		press(4'hF); press(4'hF); press(4'hF); press(4'hF);
		press(4'h1);
		tick();
		press(4'h1); press(4'h2); press(4'h3); press(4'h4);
		press(4'h4);
		tick(); tick();
		press(4'h0); press(4'h0); press(4'h0); press(4'h5);
		tick();
		press(4'h1); press(4'h2); press(4'h3); press(4'h3);
		tick();

		// full-width register values, then medium holds, zero holds and an
		// attempts limit of zero
		wait_for_results();
		cfg_write(REG_PIN_CODE, 32'hFFFF);
		cfg_write(REG_KEY_GAP, 32'hFFFF);
		cfg_write(REG_OPEN, 32'hFFFF);
		cfg_write(REG_ERROR, 32'hFFFF);
		cfg_write(REG_LOCKOUT, 32'hFFFF);
		cfg_write(REG_MAX_ATTEMPTS, 32'd3);
		check_registers();
		cfg_write(REG_KEY_GAP, 32'd24);
		cfg_write(REG_OPEN, 32'd24);
		cfg_write(REG_ERROR, 32'd24);
		cfg_write(REG_LOCKOUT, 32'd24);
		rush = 1'b1;
		press(4'hF);
		press(4'h0);
		ride_out();
		wait_for_results();
		cfg_write(REG_KEY_GAP, 32'd0);
		press(4'hF); press(4'hF); press(4'hF);
		ride_out();
		enter_code(16'h0000);
		ride_out();
		wait_for_results();
		cfg_write(REG_ERROR, 32'd0);
		enter_code(16'hFFF0);
		ride_out();
		enter_code(16'h0000);
		wait_for_results();
		cfg_write(REG_MAX_ATTEMPTS, 32'd0);
		ride_out();
		wait_for_results();
		cfg_write(REG_LOCKOUT, 32'd0);
		cfg_write(REG_OPEN, 32'd0);
		enter_code(16'hFFFF);
		ride_out();
		enter_code(16'h1111);
		ride_out();
		rush = 1'b0;

		// random settings, mostly well-formed entries with random content
		for (int ph = 0; ph < 6; ph++) begin
			wait_for_results();
			cfg_write(REG_PIN_CODE, $urandom_range(0, 65535));
			cfg_write(REG_MAX_ATTEMPTS, $urandom_range(0, 3));
			cfg_write(REG_KEY_GAP, $urandom_range(0, 3));
			cfg_write(REG_OPEN, $urandom_range(0, 6));
			cfg_write(REG_ERROR, $urandom_range(0, 6));
			cfg_write(REG_LOCKOUT, $urandom_range(0, 6));
			n_settings++;
			target = effective + 95;
			while (effective < target) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					case ($urandom_range(0, 3))
						0, 1:    code = sb.cfg.pin_code;
						2:       code = sb.cfg.pin_code ^ (16'h1 << $urandom_range(0, 15));
						default: code = 16'($urandom_range(0, 65535));
					endcase
					enter_code(code);
				end else if (pick < 9) begin
					if ($urandom_range(0, 1) == 0) tick();
					else press(4'($urandom_range(0, 15)));
				end else begin
					ride_out();
				end
				// hold off now and then until the pipeline is empty
				if ($urandom_range(0, 60) == 0) wait_for_results();
			end
		end

		wait_for_results();
		repeat (10) @(posedge clk);
		$display("covered: %0d transfers in, %0d statuses checked, %0d random settings",
			sent, sb.checked, n_settings);
		$display("covered: %0d matches, %0d mismatches, %0d lockouts, holds of 0 to 24 ticks",
			sb.n_match, sb.n_miss, sb.n_lockout);
		if (sb.failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
